FILE: sv/dtps_pkg.sv
// ---------------------------------------------------------------------------
// dtps_pkg
// Shared types and codes of the depth-tested pixel store: transaction
// payloads, operation codes and control register indexes.
// ---------------------------------------------------------------------------
package dtps_pkg;

   // operation codes of a request transaction
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // control register indexes
   localparam logic [1:0] CSR_AA_ENABLE = 2'd0;
   localparam logic [1:0] CSR_BG_RED    = 2'd1;
   localparam logic [1:0] CSR_BG_GREEN  = 2'd2;
   localparam logic [1:0] CSR_BG_BLUE   = 2'd3;

   // field widths of the transactions
   localparam int COORD_W = 9;
   localparam int DEPTH_W = 24;
   localparam int CHAN_W  = 8;

   // request transaction payload
   typedef struct packed {
      logic [1:0]                op;
      logic [COORD_W-1:0]        x_coord;
      logic [COORD_W-1:0]        y_coord;
      logic signed [DEPTH_W-1:0] depth;
      logic [CHAN_W-1:0]         frag_red;
      logic [CHAN_W-1:0]         frag_green;
      logic [CHAN_W-1:0]         frag_blue;
   } req_type;

   // response transaction payload
   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
   } rsp_type;

endpackage

FILE: sv/depth_tested_pixel_store.sv
// ---------------------------------------------------------------------------
// depth_tested_pixel_store
// Z-buffered pixel store with depth-tested fragment writes, exact or 2x2
// box-averaged reads and a clear-all operation.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every pixel lives
// in one RAM word (valid bit, depth, color) that is read and written back,
// so a fragment write reads the word, then writes it back if the depth
// test passes; an exact read fetches one sample and an antialiased read
// streams four samples through the one RAM read port, then forms the
// result. The response appears on rsp_data with rsp_valid high for
// exactly one cycle, the cycle after the last sample, and must be taken
// then: it cannot be held off. A new request may start in that same cycle.
// A clear, and likewise reset, sweeps the whole RAM one word per cycle,
// with busy high throughout; control register writes are taken at any time.
// ---------------------------------------------------------------------------
module depth_tested_pixel_store #(
   parameter int FRAME_WIDTH  = 512,
   parameter int FRAME_HEIGHT = 512,
   parameter int DEPTH_BITS   = 24,
   parameter int COLOR_BITS   = 8
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  dtps_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   output dtps_pkg::rsp_type rsp_data,
   // control registers
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   // stored widths
   localparam int DW    = (DEPTH_BITS < dtps_pkg::DEPTH_W) ? DEPTH_BITS : dtps_pkg::DEPTH_W;
   localparam int CW    = (COLOR_BITS < dtps_pkg::CHAN_W) ? COLOR_BITS : dtps_pkg::CHAN_W;
   localparam int AW_X  = $clog2(FRAME_WIDTH);
   localparam int AW_Y  = $clog2(FRAME_HEIGHT);
   localparam int AW    = AW_X + AW_Y;
   localparam int XCW   = (AW_X > dtps_pkg::COORD_W) ? AW_X : dtps_pkg::COORD_W;
   localparam int YCW   = (AW_Y > dtps_pkg::COORD_W) ? AW_Y : dtps_pkg::COORD_W;
   localparam int WORD_W = 1 + DW + 3 * CW;
   localparam logic [XCW:0] X_LIM = (XCW + 1)'(FRAME_WIDTH);
   localparam logic [YCW:0] Y_LIM = (YCW + 1)'(FRAME_HEIGHT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_WRITE,
      ST_READ
   } state_type;

   state_type state_ff, state_in;
   dtps_pkg::req_type item_ff, item_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [AW-1:0]           sweep_ff, sweep_in;
   logic [1:0]              proc_ff, proc_in;
   logic                    smp_in_ff, smp_in_in;
   logic                    pix_in_ff, pix_in_in;
   logic [2:0][CW+1:0]      acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   dtps_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic                    aa_enable_ff;
   logic [2:0][CW-1:0]      bg_ff;

   // sample address path
   logic                               idle;
   logic [1:0]                         iss;
   logic [dtps_pkg::COORD_W-1:0]       base_x, base_y, xs, ys;
   logic [XCW-1:0]                     xs_ext;
   logic [YCW-1:0]                     ys_ext;
   logic                               iss_in_frame;
   logic [AW-1:0]                      rd_addr;

   // ram side
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [WORD_W-1:0]   ram_wdata;
   logic [WORD_W-1:0]   ram_rdata;
   logic                rd_valid;
   logic [DW-1:0]       rd_depth;
   logic [2:0][CW-1:0]  rd_color;
   logic [2:0][CW-1:0]  frag_color;
   logic [2:0][CW-1:0]  samp_color;
   logic [2:0][CW+1:0]  sum;
   logic                upd;
   logic                last;
   logic                accept;

   assign idle   = (state_ff == ST_IDLE);
   assign busy   = !idle;
   assign accept = start && idle;

   // coordinates of the sample read issued this cycle
   assign iss    = idle ? 2'd0 : 2'(proc_ff + 2'd1);
   assign base_x = idle ? req_data.x_coord : item_ff.x_coord;
   assign base_y = idle ? req_data.y_coord : item_ff.y_coord;
   assign xs     = base_x ^ dtps_pkg::COORD_W'(iss[1]);
   assign ys     = base_y ^ dtps_pkg::COORD_W'(iss[0]);
   assign xs_ext = XCW'(xs);
   assign ys_ext = YCW'(ys);
   assign iss_in_frame = ({1'b0, xs_ext} < X_LIM) && ({1'b0, ys_ext} < Y_LIM);
   assign rd_addr = {ys_ext[AW_Y-1:0], xs_ext[AW_X-1:0]};

   // unpack the stored word
   assign rd_valid = ram_rdata[WORD_W-1];
   assign rd_depth = ram_rdata[3*CW +: DW];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rd_color[k] = ram_rdata[k*CW +: CW];
      end
   end

   // fragment color, low bits of each channel
   assign frag_color[0] = item_ff.frag_red[CW-1:0];
   assign frag_color[1] = item_ff.frag_green[CW-1:0];
   assign frag_color[2] = item_ff.frag_blue[CW-1:0];

   // depth test: empty pixel or strictly closer fragment wins
   assign upd = !rd_valid || ($signed(item_ff.depth[DW-1:0]) < $signed(rd_depth));

   // sample color and running sum
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         samp_color[k] = (smp_in_ff && rd_valid) ? rd_color[k] : bg_ff[k];
         sum[k]        = acc_ff[k] + (CW + 2)'(samp_color[k]);
      end
   end

   assign last = aa_enable_ff ? (proc_ff == 2'd3) : 1'b1;

   // ram write port: clearing sweep or depth-test write-back
   assign ram_we    = (state_ff == ST_SWEEP) || ((state_ff == ST_WRITE) && upd);
   assign ram_waddr = (state_ff == ST_SWEEP) ? sweep_ff : addr_ff;
   assign ram_wdata = (state_ff == ST_SWEEP) ? '0 :
                      {1'b1, item_ff.depth[DW-1:0], frag_color[2], frag_color[1],
                       frag_color[0]};

   dtps_ram #(
      .WIDTH (WORD_W),
      .DEPTH (2 ** AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      addr_in      = addr_ff;
      sweep_in     = sweep_ff;
      proc_in      = proc_ff;
      smp_in_in    = smp_in_ff;
      pix_in_in    = pix_in_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in   = req_data;
               addr_in   = rd_addr;
               proc_in   = 2'd0;
               smp_in_in = iss_in_frame;
               pix_in_in = iss_in_frame;
               acc_in    = '0;
               unique case (req_data.op)
                  dtps_pkg::OP_WRITE: begin
                     if (iss_in_frame) begin
                        state_in = ST_WRITE;
                     end
                  end
                  dtps_pkg::OP_READ: begin
                     state_in = ST_READ;
                  end
                  dtps_pkg::OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            sweep_in = AW'(sweep_ff + 1'b1);
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            acc_in    = sum;
            proc_in   = iss;
            // a read outside the frame returns background for every sample
            smp_in_in = iss_in_frame && pix_in_ff;
            if (last) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (aa_enable_ff) begin
                  rsp_data_in.out_red   = dtps_pkg::CHAN_W'(sum[0][CW+1:2]);
                  rsp_data_in.out_green = dtps_pkg::CHAN_W'(sum[1][CW+1:2]);
                  rsp_data_in.out_blue  = dtps_pkg::CHAN_W'(sum[2][CW+1:2]);
               end else begin
                  rsp_data_in.out_red   = dtps_pkg::CHAN_W'(sum[0][CW-1:0]);
                  rsp_data_in.out_green = dtps_pkg::CHAN_W'(sum[1][CW-1:0]);
                  rsp_data_in.out_blue  = dtps_pkg::CHAN_W'(sum[2][CW-1:0]);
               end
            end
         end
      endcase
   end

   // state and registered outputs; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      addr_ff     <= addr_in;
      proc_ff     <= proc_in;
      smp_in_ff   <= smp_in_in;
      pix_in_ff   <= pix_in_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         aa_enable_ff <= 1'b0;
         bg_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            dtps_pkg::CSR_AA_ENABLE: aa_enable_ff <= csr_wdata[0];
            dtps_pkg::CSR_BG_RED:    bg_ff[0]     <= csr_wdata[CW-1:0];
            dtps_pkg::CSR_BG_GREEN:  bg_ff[1]     <= csr_wdata[CW-1:0];
            dtps_pkg::CSR_BG_BLUE:   bg_ff[2]     <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/dtps_ram.sv
// ---------------------------------------------------------------------------
// dtps_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No reset on the contents.
// ---------------------------------------------------------------------------
module dtps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
